// ===== rtl/pad_link_poll_manager_top_assert.svh =====
// assertion macros used by the pad link manager datapath
`ifndef PAD_LINK_POLL_MANAGER_TOP_ASSERT_SVH
`define PAD_LINK_POLL_MANAGER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define PLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pad link manager check failed");

// condition holds in the following cycle
`define PLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pad link manager check failed");

`endif

// ===== rtl/plp_pkg.sv =====
// types, codes and defaults of the pad link poll manager
package plp_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int MAX_RES      = 4;
    localparam int IDX_W        = 3;   // enough for the largest channel count

    localparam logic [15:0] PROBE_INTERVAL_RST = 16'd12000;
    localparam logic [15:0] POLL_INTERVAL_RST  = 16'd1000;
    localparam logic [15:0] RESP_TIMEOUT_RST   = 16'd1000;
    localparam logic [1:0]  DISCONNECT_RST     = 2'd2;

    // register indexes
    localparam logic [1:0] REG_PROBE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_POLL_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_RESP_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_DISCONNECT     = 2'd3;

    // input operations
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_REPLY   = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    // events
    localparam logic [1:0] EV_SENT       = 2'd0;
    localparam logic [1:0] EV_REPLY      = 2'd1;
    localparam logic [1:0] EV_TIMEOUT    = 2'd2;
    localparam logic [1:0] EV_DISCONNECT = 2'd3;

    // command kinds
    localparam logic [2:0] CMD_PROBE        = 3'd0;
    localparam logic [2:0] CMD_ORIGIN       = 3'd1;
    localparam logic [2:0] CMD_ORIGIN_RECAL = 3'd2;
    localparam logic [2:0] CMD_POLL         = 3'd3;
    localparam logic [2:0] CMD_POLL_RUMBLE  = 3'd4;

    // link modes
    localparam logic [1:0] LINK_NONE   = 2'd0;
    localparam logic [1:0] LINK_ORIGIN = 2'd1;
    localparam logic [1:0] LINK_POLL   = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  channel;
        logic        stop_comm;
        logic [63:0] response_data;
        logic        recal_request;
        logic        rumble_request;
    } t_in;

    typedef struct packed {
        logic [1:0]  out_channel;
        logic [1:0]  event_res;
        logic [2:0]  command;
        logic        connected;
        logic [1:0]  link_state;
        logic [63:0] pad_values;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             exec;
        logic             flush;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic stall;
        logic flush_done;
    } t_stat;

endpackage

// ===== rtl/pad_link_poll_manager_top.sv =====
// Pad link poll manager: a tick walks every channel record, one channel per cycle while the
// output side does not stall, and a reply or request visits only its own channel record.
// A result passes through the hold register into the output register; the walk stops only
// while the output side stalls.
// Synchronous active-low reset clears every channel record and the result stages
// and loads the configuration defaults.
module pad_link_poll_manager_top #(
    parameter int CHANNELS = plp_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  plp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output plp_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata
);

    plp_pkg::t_cmd  cmd;
    plp_pkg::t_stat stat;

    plp_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    plp_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/plp_ctrl.sv =====
// sequencer: accepts an item, walks the channels, then flushes the held result
module plp_ctrl #(
    parameter int CHANNELS = plp_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  plp_pkg::t_stat i_stat,
    output plp_pkg::t_cmd  o_cmd
);

    plp_pkg::t_state r_state, n_state;
    logic [plp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic last_idx;

    assign last_idx = !i_stat.is_tick ||
                      (r_idx == plp_pkg::IDX_W'(CHANNELS - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            plp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = plp_pkg::ST_EXEC;
                    n_idx   = '0;
                end
            end
            plp_pkg::ST_EXEC: begin
                if (!i_stat.stall) begin
                    if (last_idx) begin
                        n_state = plp_pkg::ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            plp_pkg::ST_FLUSH: begin
                if (i_stat.flush_done) begin
                    n_state = plp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        case (r_state)
            plp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            plp_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            plp_pkg::ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plp_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== rtl/plp_datapath.sv =====
// channel records, config registers, event logic and the result hold and output stages
`include "pad_link_poll_manager_top_assert.svh"

module plp_datapath #(
    parameter int CHANNELS = plp_pkg::CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plp_pkg::t_in    i_in_data,
    input  plp_pkg::t_cmd   i_cmd,
    output plp_pkg::t_stat  o_stat,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_addr,
    input  logic [15:0]     i_cfg_wdata,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output plp_pkg::t_out   o_out_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic [15:0] r_probe_iv, r_poll_iv, r_timeout;
    logic [1:0]  r_disc;

    // channel records
    logic [1:0]  r_mode   [CHANNELS];
    logic        r_wait   [CHANNELS];
    logic [15:0] r_elap   [CHANNELS];
    logic [1:0]  r_trun   [CHANNELS];
    logic [2:0]  r_kind   [CHANNELS];
    logic        r_linked [CHANNELS];
    logic        r_recal  [CHANNELS];
    logic        r_rumble [CHANNELS];
    logic [63:0] r_pad    [CHANNELS];

    plp_pkg::t_in  r_item;
    plp_pkg::t_out r_held, r_out, res, held_last;
    logic          r_held_v, r_out_v;
    logic [2:0]    r_cnt;

    logic [CW-1:0] sel;
    logic          is_tick, ch_ok, out_free, report, stall, step;
    logic          evt;
    logic [1:0]    ev;

    // current channel, read
    logic [1:0]  c_mode, c_trun;
    logic        c_wait, c_linked, c_recal, c_rumble;
    logic [15:0] c_elap, el1;
    logic [2:0]  c_kind;
    logic [63:0] c_pad;

    // current channel, next
    logic [1:0]  n_mode, n_trun;
    logic        n_wait, n_linked, n_recal, n_rumble;
    logic [15:0] n_elap;
    logic [2:0]  n_kind;
    logic [63:0] n_pad;
    logic        upd;

    assign is_tick = (r_item.op == plp_pkg::OP_TICK);
    assign sel     = is_tick ? i_cmd.idx[CW-1:0] : CW'(r_item.channel);
    assign ch_ok   = is_tick || (int'(r_item.channel) < CHANNELS);

    assign c_mode   = r_mode[sel];
    assign c_wait   = r_wait[sel];
    assign c_elap   = r_elap[sel];
    assign c_trun   = r_trun[sel];
    assign c_kind   = r_kind[sel];
    assign c_linked = r_linked[sel];
    assign c_recal  = r_recal[sel];
    assign c_rumble = r_rumble[sel];
    assign c_pad    = r_pad[sel];

    assign el1 = (c_elap == 16'hFFFF) ? c_elap : c_elap + 16'd1;

    always_comb begin
        n_mode   = c_mode;
        n_wait   = c_wait;
        n_elap   = c_elap;
        n_trun   = c_trun;
        n_kind   = c_kind;
        n_linked = c_linked;
        n_recal  = c_recal;
        n_rumble = c_rumble;
        n_pad    = c_pad;
        upd      = 1'b0;
        evt      = 1'b0;
        ev       = plp_pkg::EV_SENT;
        if (ch_ok) begin
            case (r_item.op)
                plp_pkg::OP_TICK: begin
                    upd    = 1'b1;
                    n_elap = el1;
                    if (!c_wait) begin
                        if (!r_item.stop_comm) begin
                            case (c_mode)
                                plp_pkg::LINK_NONE: begin
                                    if (el1 > r_probe_iv) begin
                                        evt    = 1'b1;
                                        n_kind = plp_pkg::CMD_PROBE;
                                    end
                                end
                                plp_pkg::LINK_ORIGIN: begin
                                    if (el1 > r_probe_iv) begin
                                        evt    = 1'b1;
                                        n_kind = plp_pkg::CMD_ORIGIN;
                                    end
                                end
                                plp_pkg::LINK_POLL: begin
                                    if (el1 > r_poll_iv) begin
                                        evt = 1'b1;
                                        if (c_recal) begin
                                            n_kind  = plp_pkg::CMD_ORIGIN_RECAL;
                                            n_recal = 1'b0;
                                        end else if (c_rumble) begin
                                            n_kind = plp_pkg::CMD_POLL_RUMBLE;
                                        end else begin
                                            n_kind = plp_pkg::CMD_POLL;
                                        end
                                    end
                                end
                                default: begin
                                    evt = 1'b0;   // unused mode never sends
                                end
                            endcase
                            if (evt) begin
                                n_wait = 1'b1;
                                n_elap = '0;
                                ev     = plp_pkg::EV_SENT;
                            end
                        end
                    end else if (el1 >= r_timeout) begin
                        evt    = 1'b1;
                        n_wait = 1'b0;
                        n_trun = (c_trun == 2'd3) ? c_trun : c_trun + 2'd1;
                        if (c_linked && (n_trun >= r_disc)) begin
                            n_linked = 1'b0;
                            n_mode   = plp_pkg::LINK_NONE;
                            n_pad    = '0;
                            ev       = plp_pkg::EV_DISCONNECT;
                        end else begin
                            ev = plp_pkg::EV_TIMEOUT;
                        end
                    end
                end
                plp_pkg::OP_REPLY: begin
                    if (c_wait && (c_elap < r_timeout)) begin
                        upd = 1'b1;
                        evt = 1'b1;
                        ev  = plp_pkg::EV_REPLY;
                        if (c_kind inside {plp_pkg::CMD_POLL, plp_pkg::CMD_POLL_RUMBLE}) begin
                            n_pad = r_item.response_data;
                        end else if (c_kind inside {plp_pkg::CMD_ORIGIN,
                                                    plp_pkg::CMD_ORIGIN_RECAL}) begin
                            n_mode = plp_pkg::LINK_POLL;
                        end else if (c_kind == plp_pkg::CMD_PROBE) begin
                            n_linked = 1'b1;
                            n_mode   = plp_pkg::LINK_ORIGIN;
                        end
                        n_trun = '0;
                        n_wait = 1'b0;
                    end
                end
                plp_pkg::OP_REQUEST: begin
                    upd      = 1'b1;
                    n_recal  = r_item.recal_request;
                    n_rumble = r_item.rumble_request;
                end
                default: begin
                    upd = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        res.out_channel = is_tick ? i_cmd.idx[1:0] : r_item.channel;
        res.event_res   = ev;
        res.command     = n_kind;
        res.connected   = n_linked;
        res.link_state  = n_mode;
        res.pad_values  = n_pad;
        res.last        = 1'b0;
    end

    // held result marked as the final one of its transaction
    always_comb begin
        held_last      = r_held;
        held_last.last = 1'b1;
    end

    assign out_free = !r_out_v || i_out_ready;
    assign report   = evt && (r_cnt < 3'(plp_pkg::MAX_RES));
    assign stall    = i_cmd.exec && report && r_held_v && !out_free;
    assign step     = i_cmd.exec && !stall;

    assign o_stat.is_tick    = is_tick;
    assign o_stat.stall      = stall;
    assign o_stat.flush_done = !r_held_v || out_free;

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_iv <= plp_pkg::PROBE_INTERVAL_RST;
            r_poll_iv  <= plp_pkg::POLL_INTERVAL_RST;
            r_timeout  <= plp_pkg::RESP_TIMEOUT_RST;
            r_disc     <= plp_pkg::DISCONNECT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                plp_pkg::REG_PROBE_INTERVAL: r_probe_iv <= i_cfg_wdata;
                plp_pkg::REG_POLL_INTERVAL:  r_poll_iv  <= i_cfg_wdata;
                plp_pkg::REG_RESP_TIMEOUT:   r_timeout  <= i_cfg_wdata;
                plp_pkg::REG_DISCONNECT:     r_disc     <= i_cfg_wdata[1:0];
                default:                     r_disc     <= r_disc;
            endcase
        end
    end

    // channel records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_mode[i]   <= plp_pkg::LINK_NONE;
                r_wait[i]   <= 1'b0;
                r_elap[i]   <= '0;
                r_trun[i]   <= '0;
                r_kind[i]   <= plp_pkg::CMD_PROBE;
                r_linked[i] <= 1'b0;
                r_recal[i]  <= 1'b0;
                r_rumble[i] <= 1'b0;
                r_pad[i]    <= '0;
            end
        end else if (step && upd) begin
            r_mode[sel]   <= n_mode;
            r_wait[sel]   <= n_wait;
            r_elap[sel]   <= n_elap;
            r_trun[sel]   <= n_trun;
            r_kind[sel]   <= n_kind;
            r_linked[sel] <= n_linked;
            r_recal[sel]  <= n_recal;
            r_rumble[sel] <= n_rumble;
            r_pad[sel]    <= n_pad;
        end
    end

    // item latch, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
    end

    // one result is held back until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end
            if (step && report) begin
                r_held_v <= 1'b1;
                r_cnt    <= r_cnt + 3'd1;
                if (r_held_v) begin
                    r_out_v <= 1'b1;
                end
            end
            if (i_cmd.flush && r_held_v && out_free) begin
                r_held_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && report) begin
            r_held <= res;
            if (r_held_v) begin
                r_out <= r_held;
            end
        end
        if (i_cmd.flush && r_held_v && out_free) begin
            r_out <= held_last;
        end
    end

    `PLP_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(plp_pkg::MAX_RES))
    `PLP_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, stall, r_held_v && r_out_v && i_cmd.exec)
    `PLP_ASSERT_NEXT(a_flush_empties, i_clk, i_rst_n, i_cmd.flush && out_free, !r_held_v)
    `PLP_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, step && report, r_held_v)

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the pad link poll manager: directed and random stimulus
module tb_top;
    import plp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASES = 5;

    // predicts per-channel link behavior and holds the events still owed by the block
    class pad_link_scoreboard;
        logic [15:0] probe_gap, poll_gap, reply_window;
        logic [1:0]  unlink_count;
        logic [1:0]  mode       [CHANNELS_DEF];
        bit          waiting    [CHANNELS_DEF];
        logic [15:0] since_send [CHANNELS_DEF];
        logic [1:0]  miss_run   [CHANNELS_DEF];
        logic [2:0]  last_cmd   [CHANNELS_DEF];
        bit          linked     [CHANNELS_DEF];
        bit          recal_req  [CHANNELS_DEF];
        bit          rumble_req [CHANNELS_DEF];
        logic [63:0] pad_hold   [CHANNELS_DEF];
        t_out        expected_events[$];
        t_out        batch[$];
        int          errors;

        function new();
            probe_gap    = PROBE_INTERVAL_RST;
            poll_gap     = POLL_INTERVAL_RST;
            reply_window = RESP_TIMEOUT_RST;
            unlink_count = DISCONNECT_RST;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                mode[c]       = LINK_NONE;
                waiting[c]    = 0;
                since_send[c] = '0;
                miss_run[c]   = '0;
                last_cmd[c]   = CMD_PROBE;
                linked[c]     = 0;
                recal_req[c]  = 0;
                rumble_req[c] = 0;
                pad_hold[c]   = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_PROBE_INTERVAL: probe_gap    = val;
                REG_POLL_INTERVAL:  poll_gap     = val;
                REG_RESP_TIMEOUT:   reply_window = val;
                REG_DISCONNECT:     unlink_count = val[1:0];
                default: ;
            endcase
        endfunction

        function bit reply_fits(logic [1:0] ch);
            return waiting[ch] && since_send[ch] < reply_window;
        endfunction

        // events past the fourth of one transaction take effect but go unreported
        function void log_event(int c, logic [1:0] ev);
            t_out r;
            if (batch.size() >= MAX_RES)
                return;
            r.out_channel = c[1:0];
            r.event_res   = ev;
            r.command     = last_cmd[c];
            r.connected   = linked[c];
            r.link_state  = mode[c];
            r.pad_values  = pad_hold[c];
            r.last        = 1'b0;
            batch.push_back(r);
        endfunction

        function void advance_channel(int c, bit stop);
            bit         fire;
            logic [2:0] cmd;
            fire = 0;
            cmd  = CMD_PROBE;
            if (since_send[c] != 16'hFFFF)
                since_send[c]++;
            if (!waiting[c]) begin
                if (stop)
                    return;
                case (mode[c])
                    LINK_NONE: begin
                        if (since_send[c] > probe_gap) begin
                            fire = 1;
                            cmd  = CMD_PROBE;
                        end
                    end
                    LINK_ORIGIN: begin
                        if (since_send[c] > probe_gap) begin
                            fire = 1;
                            cmd  = CMD_ORIGIN;
                        end
                    end
                    LINK_POLL: begin
                        if (since_send[c] > poll_gap) begin
                            fire = 1;
                            if (recal_req[c]) begin
                                cmd          = CMD_ORIGIN_RECAL;
                                recal_req[c] = 0;
                            end else begin
                                cmd = rumble_req[c] ? CMD_POLL_RUMBLE : CMD_POLL;
                            end
                        end
                    end
                    default: fire = 0;
                endcase
                if (fire) begin
                    waiting[c]    = 1;
                    since_send[c] = '0;
                    last_cmd[c]   = cmd;
                    log_event(c, EV_SENT);
                end
            end else if (since_send[c] >= reply_window) begin
                // a waiting channel times out even while sends are held back
                if (miss_run[c] != 2'd3)
                    miss_run[c]++;
                waiting[c] = 0;
                if (linked[c] && miss_run[c] >= unlink_count) begin
                    linked[c]   = 0;
                    mode[c]     = LINK_NONE;
                    pad_hold[c] = '0;
                    log_event(c, EV_DISCONNECT);
                end else begin
                    log_event(c, EV_TIMEOUT);
                end
            end
        endfunction

        function void note_input(t_in item);
            int ch;
            ch = item.channel;
            batch.delete();
            case (item.op)
                OP_TICK: begin
                    for (int c = 0; c < CHANNELS_DEF; c++)
                        advance_channel(c, item.stop_comm);
                end
                OP_REPLY: begin
                    if (reply_fits(item.channel)) begin
                        case (last_cmd[ch])
                            CMD_POLL, CMD_POLL_RUMBLE: pad_hold[ch] = item.response_data;
                            CMD_ORIGIN, CMD_ORIGIN_RECAL: mode[ch] = LINK_POLL;
                            CMD_PROBE: begin
                                linked[ch] = 1;
                                mode[ch]   = LINK_ORIGIN;
                            end
                            default: ;
                        endcase
                        miss_run[ch] = '0;
                        waiting[ch]  = 0;
                        log_event(ch, EV_REPLY);
                    end
                end
                OP_REQUEST: begin
                    recal_req[ch]  = item.recal_request;
                    rumble_req[ch] = item.rumble_request;
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size()-1].last = 1'b1;
            foreach (batch[i])
                expected_events.push_back(batch[i]);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                report($sformatf("%s expected %h got %h", name, want, got));
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected result ch %0d event %0d",
                                 got.out_channel, got.event_res));
                return;
            end
            want = expected_events.pop_front();
            compare_field("out_channel", 64'(want.out_channel), 64'(got.out_channel));
            compare_field("event_res", 64'(want.event_res), 64'(got.event_res));
            compare_field("command", 64'(want.command), 64'(got.command));
            compare_field("connected", 64'(want.connected), 64'(got.connected));
            compare_field("link_state", 64'(want.link_state), 64'(got.link_state));
            compare_field("pad_values", want.pad_values, got.pad_values);
            compare_field("last", 64'(want.last), 64'(got.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;

    pad_link_poll_manager_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    pad_link_scoreboard sb = new();
    bit in_burst;
    bit out_burst;
    bit hold_output;

    // per-phase settings: probe, poll, reply window, disconnect count, item count
    logic [15:0] probe_set  [PHASES] = '{16'd1, 16'd3, 16'd2, 16'd5, 16'd65535};
    logic [15:0] poll_set   [PHASES] = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd65535};
    logic [15:0] window_set [PHASES] = '{16'd1, 16'd4, 16'd6, 16'd3, 16'd65535};
    logic [15:0] unlink_set [PHASES] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd3};
    int          count_set  [PHASES] = '{70, 70, 70, 70, 20};

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #(12 * 200000);
        $display("TEST FAILED");
        $finish;
    end

    // random idle gaps, with occasional stretches of none
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic t_in mk(logic [1:0] op, logic [1:0] ch, logic stop,
                               logic [63:0] data, logic recal, logic rumble);
        t_in it;
        it.op             = op;
        it.channel        = ch;
        it.stop_comm      = stop;
        it.response_data  = data;
        it.recal_request  = recal;
        it.rumble_request = rumble;
        return it;
    endfunction

    // mostly ticks and timely replies so channels get through to polling
    function automatic t_in random_item();
        t_in it;
        int  roll;
        int  start;
        it   = mk(OP_TICK, 2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0,
                  {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            it.op = OP_TICK;
        end else if (roll < 85) begin
            it.op = OP_REPLY;
            start = $urandom_range(0, 3);
            if (roll < 81) begin
                for (int k = 0; k < CHANNELS_DEF; k++) begin
                    if (sb.reply_fits(2'(start + k))) begin
                        it.channel = 2'(start + k);
                        break;
                    end
                end
            end
        end else if (roll < 96) begin
            it.op = OP_REQUEST;
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task send_item(t_in item);
        int gap;
        gap = draw_gap(in_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(item);
    endtask

    task write_config(logic [15:0] probe, logic [15:0] poll, logic [15:0] window,
                      logic [15:0] unlink);
        logic [15:0] vals [4];
        vals = '{probe, poll, window, unlink};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= 2'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.set_reg(2'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // a tick may cause nothing yet still be in flight, so linger past the last result
    task drain();
        i_in_valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int   done;
        t_in  it;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        hold_output = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default settings: nothing is due, replies and unused ops are dropped
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_TICK, 2'd1, 1'b1, '1, 1'b1, 1'b1));
        send_item(mk(OP_REPLY, 2'd3, 1'b0, '1, 1'b0, 1'b0));
        send_item(mk(OP_REQUEST, 2'd2, 1'b0, '0, 1'b1, 1'b1));
        send_item(mk(OP_UNUSED, 2'd1, 1'b1, '1, 1'b1, 1'b1));
        send_item(mk(OP_REQUEST, 2'd2, 1'b0, '0, 1'b0, 1'b0));
        drain();

        // shortest intervals: walk channels through probe, origin and poll
        write_config(16'd1, 16'd1, 16'd2, 16'd1);
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd1, 1'b0, '1, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd2, 1'b0, 64'h5555_5555_5555_5555, 1'b0, 1'b0));
        send_item(mk(OP_REQUEST, 2'd0, 1'b0, '0, 1'b1, 1'b0));
        send_item(mk(OP_REQUEST, 2'd1, 1'b0, '0, 1'b0, 1'b1));
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd1, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd2, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_TICK, 2'd0, 1'b0, '0, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd0, 1'b0, '1, 1'b0, 1'b0));
        send_item(mk(OP_REPLY, 2'd1, 1'b0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0));
        for (int i = 0; i < 3; i++)
            send_item(mk(OP_TICK, 2'd0, 1'b1, '0, 1'b0, 1'b0));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_config(probe_set[p], poll_set[p], window_set[p], unlink_set[p]);
            if (p == 1)
                hold_output = 1;
            done = 0;
            while (done < count_set[p]) begin
                it = random_item();
                done++;
                send_item(it);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        int gap;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(out_burst);
            if (hold_output) begin
                // long back-pressure so the block fills and stops taking input
                hold_output = 0;
                gap = 400;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_data);
        end
    end

endmodule
